[design/ring_buffer_deque_defines.svh]
// Assertion macros shared by the ring buffer deque modules.
`ifndef RING_BUFFER_DEQUE_DEFINES_SVH
`define RING_BUFFER_DEQUE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RBD_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define RBD_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/rbd_pkg.sv]
// Shared types and codes for the ring buffer deque.
package rbd_pkg;

    localparam int DATA_W   = 32;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;

    localparam logic [ACTION_W-1:0] ACT_PUSH_REAR  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_REAR   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic accept;    // item taken this cycle
        logic load_pop;  // capture RAM read data into the result
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_read; // current item is a pop that removes an element
    } dp_sts_t;

endpackage

[design/ring_buffer_deque.sv]
// Top level of the ring buffer deque.
//
//  Channel  | Ports      | Contents
//  ---------+------------+-------------------------------------------------
//  input    | s_axis_*   | tuser: action; tdata: data
//  result   | m_axis_*   | tuser: status; tdata: popped_data, occupancy
//
// Pushes and refused actions register their result when accepted; a successful pop
// also passes the READ state, set by the registered read port of the slot RAM.
// A new item is taken while the previous result waits, as long as it is
// taken by the consumer in the same cycle.
// Reset (aresetn low, synchronous) empties the deque; slot contents are kept.
module ring_buffer_deque #(
    parameter int DEPTH = 16
) (
    input  logic aclk,
    input  logic aresetn,

    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  logic [rbd_pkg::DATA_W-1:0]                s_axis_tdata,  // [31:0] data
    input  logic [rbd_pkg::ACTION_W-1:0]              s_axis_tuser,  // [1:0] action

    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    output logic [((rbd_pkg::DATA_W + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0]
                                                      m_axis_tdata,  // popped_data, occupancy
    output logic [rbd_pkg::STATUS_W-1:0]              m_axis_tuser   // [1:0] status
);

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int OUT_W = ((rbd_pkg::DATA_W + CW + 7) / 8) * 8;

    rbd_pkg::dp_cmd_t cmd;
    rbd_pkg::dp_sts_t sts;

    logic [rbd_pkg::STATUS_W-1:0]           status;
    logic signed [rbd_pkg::DATA_W-1:0]      popped_data;
    logic [CW-1:0]                          occupancy;

    rbd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rbd_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .action      (s_axis_tuser),
        .data        (s_axis_tdata),
        .status      (status),
        .popped_data (popped_data),
        .occupancy   (occupancy)
    );

    assign m_axis_tuser = status;
    assign m_axis_tdata = OUT_W'({occupancy, popped_data});

endmodule

[design/rbd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/rbd_dp.sv]
// Deque datapath: indices, element count, slot RAM and result registers.
`include "ring_buffer_deque_defines.svh"

module rbd_dp #(
    parameter int DEPTH = 16,
    parameter int IW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  rbd_pkg::dp_cmd_t                cmd,
    output rbd_pkg::dp_sts_t                sts,
    input  logic [rbd_pkg::ACTION_W-1:0]    action,
    input  logic signed [rbd_pkg::DATA_W-1:0] data,
    output logic [rbd_pkg::STATUS_W-1:0]    status,
    output logic signed [rbd_pkg::DATA_W-1:0] popped_data,
    output logic [CW-1:0]                   occupancy
);

    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [rbd_pkg::STATUS_W-1:0] status_reg, res_status;
    logic [CW-1:0] occ_reg;
    logic signed [rbd_pkg::DATA_W-1:0] popped_reg;

    logic [IW-1:0] head_up, head_dn, tail_up, tail_dn;
    logic [IW-1:0] wr_addr, rd_addr;
    logic          wr_op, is_push, empty_w, full_w;
    logic [rbd_pkg::DATA_W-1:0] ram_rdata;

    assign head_up = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign head_dn = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
    assign tail_up = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
    assign tail_dn = (tail_reg == '0) ? LAST_IDX : tail_reg - 1'b1;

    assign is_push = (action == rbd_pkg::ACT_PUSH_REAR) || (action == rbd_pkg::ACT_PUSH_FRONT);
    assign empty_w = (count_reg == '0);
    assign full_w  = (count_reg == FULL_CNT);

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        res_status = rbd_pkg::ST_DONE;
        wr_op      = 1'b0;
        wr_addr    = tail_up;
        rd_addr    = head_reg;
        if (is_push) begin
            if (full_w) begin
                res_status = rbd_pkg::ST_FULL;
            end else begin
                wr_op      = 1'b1;
                count_next = count_reg + 1'b1;
                if (empty_w) begin
                    wr_addr   = '0;
                    head_next = '0;
                    tail_next = '0;
                end else if (action == rbd_pkg::ACT_PUSH_REAR) begin
                    wr_addr   = tail_up;
                    tail_next = tail_up;
                end else begin
                    wr_addr   = head_dn;
                    head_next = head_dn;
                end
            end
        end else begin
            if (empty_w) begin
                res_status = rbd_pkg::ST_EMPTY;
            end else begin
                count_next = count_reg - 1'b1;
                if (action == rbd_pkg::ACT_POP_FRONT) begin
                    rd_addr = head_reg;
                    if (count_reg > CW'(1)) begin
                        head_next = head_up;
                    end
                end else begin
                    rd_addr = tail_reg;
                    if (count_reg > CW'(1)) begin
                        tail_next = tail_dn;
                    end
                end
            end
        end
    end

    assign sts.need_read = !is_push && !empty_w;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else if (cmd.accept) begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            status_reg <= res_status;
            occ_reg    <= count_next;
            popped_reg <= '0;
        end else if (cmd.load_pop) begin
            popped_reg <= ram_rdata;
        end
    end

    rbd_ram #(
        .WIDTH (rbd_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (cmd.accept && wr_op),
        .wr_addr (wr_addr),
        .wr_data (data),
        .rd_en   (cmd.accept && sts.need_read),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    assign status      = status_reg;
    assign popped_data = popped_reg;
    assign occupancy   = occ_reg;

    `RBD_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= FULL_CNT, "count over depth")
    `RBD_ASSERT_NXT(a_full_hold, aclk, aresetn, cmd.accept && is_push && full_w, $stable(count_reg) && status_reg == rbd_pkg::ST_FULL, "refused push changed count")

endmodule

[design/rbd_ctrl.sv]
// Deque controller: accept/read sequencing and output item handshake.
`include "ring_buffer_deque_defines.svh"

module rbd_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  rbd_pkg::dp_sts_t sts,
    output rbd_pkg::dp_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic accept;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (sts.need_read) begin
                        state_next   = ST_READ;
                        m_valid_next = 1'b0;
                    end else begin
                        m_valid_next = 1'b1;
                    end
                end
            end
            ST_READ: begin
                state_next   = ST_IDLE;
                m_valid_next = 1'b1;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign cmd.accept   = accept;
    assign cmd.load_pop = (state_reg == ST_READ);
    assign m_valid      = m_valid_reg;

    `RBD_ASSERT_NXT(a_read_enter, aclk, aresetn, accept && sts.need_read, state_reg == ST_READ, "pop did not start read")
    `RBD_ASSERT_NXT(a_read_done, aclk, aresetn, state_reg == ST_READ, state_reg == ST_IDLE && m_valid_reg, "read did not post item")
    `RBD_ASSERT_IMP(a_read_free, aclk, aresetn, state_reg == ST_READ, !m_valid_reg, "result register busy during read")

endmodule
